>>> hw/rtl/vsd_pkg.sv
// Package for the varint stream decoder: request structs, result kinds,
// register indexes and the control group between the top level and the core.
// No dependencies.
package vsd_pkg;

  typedef enum logic [2:0] {
    KIND_VALUE    = 3'd0,
    KIND_PAYLOAD  = 3'd1,
    KIND_EMPTY    = 3'd2,
    KIND_OVERLONG = 3'd3,
    KIND_TRUNC    = 3'd4
  } kind_e;

  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CFG_WIDE_MODE   = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_FRAMED_MODE = 2'd1;

  // Maximum byte counts of a varint
  localparam logic [3:0] MaxBytesNarrow = 4'd5;
  localparam logic [3:0] MaxBytesWide   = 4'd10;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_buffer;
  } in_item_t;

  typedef struct packed {
    kind_e       kind;
    logic [63:0] value;
    logic [7:0]  payload_byte;
    logic        slice_last;
  } out_item_t;

  typedef struct packed {
    logic wide_mode;
    logic framed_mode;
    logic clear;
    logic take;
  } core_ctrl_t;

endpackage

>>> hw/rtl/varint_stream_decoder_top.sv
// Varint stream decoder top level: configuration registers, input handshake,
// decode core and the output register with skid stage.
// Depends on vsd_pkg and vsd_core.
// Each result is registered in the output register, or in the skid stage while the output stalls.
// Throughput: one byte per cycle while in_stall_o is low, set by the single-pass core update of the parse state.
// in_stall_o rises only while both the output register and the skid stage hold results.
// Reset (rst_ni low, asynchronous): both modes 0, parse state cleared, no result held.
// Any configuration write also clears the parse state.
module varint_stream_decoder_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [vsd_pkg::CfgIdxW-1:0]         cfg_idx_i,
  input  logic                                cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  vsd_pkg::in_item_t                   in_item_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output vsd_pkg::out_item_t                  out_item_o
);

  logic               wide_mode_q;
  logic               framed_mode_q;
  logic               out_valid_q;
  logic               skid_valid_q;
  vsd_pkg::out_item_t out_item_q;
  vsd_pkg::out_item_t skid_item_q;

  vsd_pkg::core_ctrl_t ctrl;
  logic                res_valid;
  vsd_pkg::out_item_t  res;
  logic                in_fire;
  logic                out_fire;
  logic                res_fire;

  assign in_stall_o  = skid_valid_q;
  assign in_fire     = in_valid_i & ~skid_valid_q;
  assign out_fire    = out_valid_q & ~out_stall_i;
  assign res_fire    = in_fire & res_valid;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  always_comb begin
    ctrl.wide_mode   = wide_mode_q;
    ctrl.framed_mode = framed_mode_q;
    ctrl.clear       = cfg_we_i;
    ctrl.take        = in_fire;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wide_mode_q   <= 1'b0;
      framed_mode_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        vsd_pkg::CFG_WIDE_MODE:   wide_mode_q   <= cfg_data_i;
        vsd_pkg::CFG_FRAMED_MODE: framed_mode_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  vsd_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .item_i      (in_item_i),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      // advance the skid entry once the output register drains
      if (out_fire) begin
        skid_valid_q <= 1'b0;
      end
    end else if (res_fire) begin
      if (!out_valid_q || out_fire) begin
        out_valid_q <= 1'b1;
      end else begin
        skid_valid_q <= 1'b1;
      end
    end else if (out_fire) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_fire) begin
        out_item_q <= skid_item_q;
      end
    end else if (res_fire) begin
      if (!out_valid_q || out_fire) begin
        out_item_q <= res;
      end else begin
        skid_item_q <= res;
      end
    end
  end

  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid stage full while output register empty");

  a_result_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_fire |=> out_valid_q)
    else $error("accepted result not held in output register");

  a_stall_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i && !skid_valid_q && res_fire) |=> skid_valid_q)
    else $error("result lost while output stalled");

endmodule

>>> hw/rtl/vsd_core.sv
// Decode core of the varint stream decoder: parse state registers and the
// single-pass next-state and result logic for one byte.
// Depends on vsd_pkg.
module vsd_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  vsd_pkg::core_ctrl_t ctrl_i,
  input  vsd_pkg::in_item_t   item_i,
  output logic                res_valid_o,
  output vsd_pkg::out_item_t  res_o
);

  logic [63:0] acc_q, acc_d;
  logic [3:0]  gcount_q, gcount_d;
  logic        in_payload_q, in_payload_d;
  logic [31:0] bytes_left_q, bytes_left_d;

  logic        wide;
  logic [3:0]  max_bytes;
  logic [3:0]  gc;
  logic [3:0]  gc_inc;
  logic [6:0]  shift_w;
  logic [63:0] acc_new;
  logic [31:0] left_m1;

  always_comb begin
    wide      = ctrl_i.wide_mode & ~ctrl_i.framed_mode;
    max_bytes = wide ? vsd_pkg::MaxBytesWide : vsd_pkg::MaxBytesNarrow;
    gc        = (gcount_q >= max_bytes) ? 4'd0 : gcount_q;
    gc_inc    = gc + 4'd1;
    // shift = gc * 7
    shift_w   = ({3'd0, gc} << 3) - {3'd0, gc};
    acc_new   = acc_q | ({57'd0, item_i.in_byte[6:0]} << shift_w[5:0]);
    if (!wide) begin
      acc_new[63:32] = 32'd0;
    end
    left_m1 = bytes_left_q - 32'd1;

    acc_d        = acc_q;
    gcount_d     = gcount_q;
    in_payload_d = in_payload_q;
    bytes_left_d = bytes_left_q;
    res_valid_o  = 1'b0;
    res_o        = '{kind: vsd_pkg::KIND_VALUE, value: 64'd0, payload_byte: 8'd0,
                     slice_last: 1'b0};

    if (in_payload_q) begin
      res_valid_o = 1'b1;
      if (left_m1 == 32'd0) begin
        in_payload_d       = 1'b0;
        bytes_left_d       = 32'd0;
        res_o.kind         = vsd_pkg::KIND_PAYLOAD;
        res_o.payload_byte = item_i.in_byte;
        res_o.slice_last   = 1'b1;
      end else if (item_i.end_of_buffer) begin
        in_payload_d = 1'b0;
        bytes_left_d = 32'd0;
        acc_d        = 64'd0;
        gcount_d     = 4'd0;
        res_o.kind   = vsd_pkg::KIND_TRUNC;
      end else begin
        bytes_left_d       = left_m1;
        res_o.kind         = vsd_pkg::KIND_PAYLOAD;
        res_o.payload_byte = item_i.in_byte;
      end
    end else if (item_i.in_byte[7]) begin
      if (gc_inc >= max_bytes) begin
        acc_d       = 64'd0;
        gcount_d    = 4'd0;
        res_valid_o = 1'b1;
        res_o.kind  = vsd_pkg::KIND_OVERLONG;
      end else if (item_i.end_of_buffer) begin
        acc_d       = 64'd0;
        gcount_d    = 4'd0;
        res_valid_o = 1'b1;
        res_o.kind  = vsd_pkg::KIND_TRUNC;
      end else begin
        acc_d    = acc_new;
        gcount_d = gc_inc;
      end
    end else begin
      acc_d       = 64'd0;
      gcount_d    = 4'd0;
      res_valid_o = 1'b1;
      if (!ctrl_i.framed_mode) begin
        res_o.value = acc_new;
      end else if (acc_new == 64'd0) begin
        res_o.kind = vsd_pkg::KIND_EMPTY;
      end else if (item_i.end_of_buffer) begin
        res_o.kind = vsd_pkg::KIND_TRUNC;
      end else begin
        // Length is a varint32, so the low word holds all of it
        in_payload_d = 1'b1;
        bytes_left_d = acc_new[31:0];
        res_o.value  = acc_new;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q        <= 64'd0;
      gcount_q     <= 4'd0;
      in_payload_q <= 1'b0;
      bytes_left_q <= 32'd0;
    end else if (ctrl_i.clear) begin
      acc_q        <= 64'd0;
      gcount_q     <= 4'd0;
      in_payload_q <= 1'b0;
      bytes_left_q <= 32'd0;
    end else if (ctrl_i.take) begin
      acc_q        <= acc_d;
      gcount_q     <= gcount_d;
      in_payload_q <= in_payload_d;
      bytes_left_q <= bytes_left_d;
    end
  end

  a_clear_resets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.clear |=> (gcount_q == 4'd0 && !in_payload_q && acc_q == 64'd0))
    else $error("parse state not cleared after register write");

  a_payload_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_payload_q == (bytes_left_q != 32'd0))
    else $error("payload flag and byte count disagree");

  a_gcount_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    gcount_q < vsd_pkg::MaxBytesWide)
    else $error("group count beyond maximum varint length");

endmodule
